// ===== design/assert_macros.svh =====
// assertion macros used by the checker file nfp_checker.sv
// no dependencies; include once per compilation unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is high
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== design/nfp_pkg.sv =====
// shared types and constants of the netstring frame parser
// no dependencies; used by the front, queue, back and top modules
package nfp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 25;
  localparam int unsigned CNT_W  = 32;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD = 25'd16777216;
  localparam logic [LEN_W-1:0] CAP_RESET   = 25'd16777216;

  // result tdata width, packed fields rounded up to whole bytes
  localparam int unsigned RES_DATA_W = BYTE_W + 2 + LEN_W + CNT_W;
  localparam int unsigned TDATA_W    = ((RES_DATA_W + 7) / 8) * 8;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7a;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FORMAT = 2'd1,
    ST_LENGTH = 2'd2,
    ST_TRUNC  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_DIGITS  = 4'b0001,
    PH_PAYLOAD = 4'b0010,
    PH_COMMA   = 4'b0100,
    PH_DISCARD = 4'b1000
  } phase_t;

  // one result item, kind in the lowest bit
  typedef struct packed {
    logic [CNT_W-1:0]  consumed;
    logic [LEN_W-1:0]  flen;
    status_t           code;
    logic [BYTE_W-1:0] data;
    logic              kind;
  } res_t;

endpackage

// ===== design/nfp_front.sv =====
// front part: takes input bytes, runs the netstring parse state, builds result records
// depends on nfp_pkg
module nfp_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [nfp_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                     in_valid,
  input  logic [7:0]               in_data,
  input  logic                     in_last,
  output logic                     in_ready,
  input  logic                     q_full,
  output logic                     push,
  output nfp_pkg::res_t            push_res
);

  logic [nfp_pkg::LEN_W-1:0] capacity;
  nfp_pkg::phase_t           phase, phase_next;
  logic [nfp_pkg::LEN_W-1:0] len_acc, len_acc_next;
  logic                      over_limit, over_limit_next;
  logic [nfp_pkg::CNT_W-1:0] digit_count, digit_count_next;
  logic [nfp_pkg::LEN_W-1:0] remaining, remaining_next;
  logic                      normalize, normalize_next;
  logic                      suppress, suppress_next;
  logic                      first_payload, first_payload_next;

  logic                      in_fire;
  logic                      is_digit;
  logic                      is_lower;
  logic [28:0]               acc_mul;
  logic                      mul_over;
  logic [nfp_pkg::CNT_W:0]   ok_sum;
  logic [nfp_pkg::CNT_W-1:0] ok_consumed;
  logic                      emit;
  nfp_pkg::status_t          emit_code;
  logic                      norm_eff;
  logic [nfp_pkg::LEN_W-1:0] rem_dec;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  assign is_digit = in_data inside {[nfp_pkg::CH_ZERO:nfp_pkg::CH_NINE]};
  assign is_lower = in_data inside {[nfp_pkg::CH_LOW_A:nfp_pkg::CH_LOW_Z]};

  // length * 10 + digit as shift-adds
  assign acc_mul  = ({4'b0, len_acc} << 3) + ({4'b0, len_acc} << 1)
                  + {25'b0, in_data[3:0]};
  assign mul_over = acc_mul > {4'b0, nfp_pkg::MAX_PAYLOAD};

  assign ok_sum      = {1'b0, digit_count} + {8'b0, len_acc} + 33'd2;
  assign ok_consumed = ok_sum[nfp_pkg::CNT_W] ? '1 : ok_sum[nfp_pkg::CNT_W-1:0];

  assign norm_eff = first_payload ? (in_data == nfp_pkg::CH_BANG) : normalize;
  assign rem_dec  = (remaining != '0) ? remaining - 25'd1 : remaining;

  always_comb begin
    phase_next         = phase;
    len_acc_next       = len_acc;
    over_limit_next    = over_limit;
    digit_count_next   = digit_count;
    remaining_next     = remaining;
    normalize_next     = normalize;
    suppress_next      = suppress;
    first_payload_next = first_payload;
    emit               = 1'b0;
    emit_code          = nfp_pkg::ST_OK;
    push               = 1'b0;
    push_res           = '0;

    if (in_fire) begin
      case (phase)
        nfp_pkg::PH_DIGITS: begin
          if (is_digit) begin
            if (digit_count != '1) begin
              digit_count_next = digit_count + 32'd1;
            end
            if (!over_limit) begin
              if (mul_over) begin
                over_limit_next = 1'b1;
              end else begin
                len_acc_next = acc_mul[nfp_pkg::LEN_W-1:0];
              end
            end
            if (in_last) begin
              emit      = 1'b1;
              emit_code = over_limit_next ? nfp_pkg::ST_LENGTH : nfp_pkg::ST_FORMAT;
            end
          end else if (digit_count == '0) begin
            emit      = 1'b1;
            emit_code = nfp_pkg::ST_FORMAT;
          end else if (over_limit) begin
            emit      = 1'b1;
            emit_code = nfp_pkg::ST_LENGTH;
          end else if (in_data != nfp_pkg::CH_COLON) begin
            emit      = 1'b1;
            emit_code = nfp_pkg::ST_FORMAT;
          end else if (in_last) begin
            emit      = 1'b1;
            emit_code = nfp_pkg::ST_TRUNC;
          end else begin
            // capacity sampled at the colon
            suppress_next  = len_acc > capacity;
            remaining_next = len_acc;
            phase_next     = (len_acc == '0) ? nfp_pkg::PH_COMMA : nfp_pkg::PH_PAYLOAD;
          end
        end
        nfp_pkg::PH_PAYLOAD: begin
          if (in_last) begin
            emit      = 1'b1;
            emit_code = nfp_pkg::ST_TRUNC;
          end else begin
            if (first_payload) begin
              normalize_next     = norm_eff;
              first_payload_next = 1'b0;
            end
            remaining_next = rem_dec;
            if (rem_dec == '0) begin
              phase_next = nfp_pkg::PH_COMMA;
            end
            if (!suppress) begin
              push          = 1'b1;
              push_res.kind = nfp_pkg::KIND_PAYLOAD;
              push_res.data = (norm_eff && is_lower) ? (in_data & ~nfp_pkg::CASE_BIT)
                                                     : in_data;
            end
          end
        end
        nfp_pkg::PH_COMMA: begin
          emit = 1'b1;
          if (in_data != nfp_pkg::CH_COMMA) begin
            emit_code = nfp_pkg::ST_FORMAT;
          end else if (suppress) begin
            emit_code = nfp_pkg::ST_LENGTH;
          end else begin
            emit_code = nfp_pkg::ST_OK;
          end
        end
        nfp_pkg::PH_DISCARD: begin
          phase_next = nfp_pkg::PH_DISCARD;
        end
        default: begin
          phase_next = nfp_pkg::PH_DISCARD;
        end
      endcase

      if (emit) begin
        push          = 1'b1;
        push_res.kind = nfp_pkg::KIND_STATUS;
        push_res.code = emit_code;
        if (emit_code == nfp_pkg::ST_OK) begin
          push_res.flen     = len_acc;
          push_res.consumed = ok_consumed;
        end
        phase_next = nfp_pkg::PH_DISCARD;
      end

      // the last byte of a buffer always starts a fresh frame
      if (in_last) begin
        phase_next         = nfp_pkg::PH_DIGITS;
        len_acc_next       = '0;
        over_limit_next    = 1'b0;
        digit_count_next   = '0;
        remaining_next     = '0;
        normalize_next     = 1'b0;
        suppress_next      = 1'b0;
        first_payload_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= nfp_pkg::CAP_RESET;
      phase         <= nfp_pkg::PH_DIGITS;
      len_acc       <= '0;
      over_limit    <= 1'b0;
      digit_count   <= '0;
      remaining     <= '0;
      normalize     <= 1'b0;
      suppress      <= 1'b0;
      first_payload <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      phase         <= phase_next;
      len_acc       <= len_acc_next;
      over_limit    <= over_limit_next;
      digit_count   <= digit_count_next;
      remaining     <= remaining_next;
      normalize     <= normalize_next;
      suppress      <= suppress_next;
      first_payload <= first_payload_next;
    end
  end

endmodule

// ===== design/nfp_queue.sv =====
// short result queue between the parse front and the output back
// depends on nfp_pkg
module nfp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  nfp_pkg::res_t push_res,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output nfp_pkg::res_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  nfp_pkg::res_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/nfp_back.sv =====
// back part: output register that presents results on the master stream
// depends on nfp_pkg
module nfp_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  nfp_pkg::res_t                q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [nfp_pkg::TDATA_W-1:0]  out_data,
  output logic                         out_kind
);

  nfp_pkg::res_t out_res;

  // refill whenever the register is empty or being drained
  assign q_pop = !q_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_res <= q_head;
    end
  end

  assign out_kind = out_res.kind;
  assign out_data = {{(nfp_pkg::TDATA_W - nfp_pkg::RES_DATA_W){1'b0}},
                     out_res.consumed, out_res.flen, out_res.code, out_res.data};

endmodule

// ===== design/netstring_frame_parser_top.sv =====
// netstring frame parser: a result passes a queue entry, then the output register, before it is valid
// throughput one byte per cycle while the queue is not full, set by the parse update in the front
// a result waits in a QUEUE_DEPTH-entry queue and the output register when the sink stalls
// synchronous active-high reset: parse state to its start, capacity to 16777216,
// queue and output register empty
module netstring_frame_parser_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: output capacity in bytes
  input  logic        cfg_wr_en,
  input  logic [24:0] cfg_wr_data,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tlast,   // last_byte
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // out_byte[7:0], status_code[9:8],
                                      // frame_length[34:10], bytes_consumed[66:35], zero pad
  output logic        m_axis_tuser    // item_kind
);

  // front to queue
  logic          push;
  nfp_pkg::res_t push_res;
  logic          q_full;
  // queue to back
  logic          q_pop;
  logic          q_empty;
  nfp_pkg::res_t q_head;

  // front: parses each byte in the cycle it is accepted; stalls only when the queue is full
  nfp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_axis_tvalid),
    .in_data     (s_axis_tdata),
    .in_last     (s_axis_tlast),
    .in_ready    (s_axis_tready),
    .q_full      (q_full),
    .push        (push),
    .push_res    (push_res)
  );

  // queue decouples parsing from the downstream stall
  nfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_res (push_res),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // back: output register, refilled from the queue whenever it is empty or the sink takes its result
  nfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_kind  (m_axis_tuser)
  );

endmodule

// ===== design/nfp_checker.sv =====
// port-level checks of the netstring frame parser, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module nfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  logic        is_status;
  logic        is_ok;
  logic [32:0] min_consumed;

  assign is_status    = m_axis_tvalid && m_axis_tuser;
  assign is_ok        = is_status && (m_axis_tdata[9:8] == 2'd0);
  assign min_consumed = {8'b0, m_axis_tdata[34:10]} + 33'd3;

  // a stalled result holds its payload
  `ASSERT_NXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
              m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // nothing is offered right after reset
  `ASSERT_IMP(a_rst_empty, clk, rst, $past(rst), !m_axis_tvalid)

  // ok status counts at least one digit, colon and comma around the payload
  `ASSERT_IMP(a_ok_count, clk, rst, is_ok, {1'b0, m_axis_tdata[66:35]} >= min_consumed)

  // failed status and payload items carry no length or count
  `ASSERT_IMP(a_zero_fields, clk, rst, m_axis_tvalid && !is_ok, m_axis_tdata[66:10] == '0)

endmodule

bind netstring_frame_parser_top nfp_checker u_nfp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb_netstring_frame_parser_top.sv =====
`timescale 1ns / 100ps
// self-checking bench for the netstring frame parser: directed frames, then random buffers
// predicts every payload byte and status from its own parse model; needs nfp_pkg and the top

module tb_netstring_frame_parser_top;

  localparam int unsigned SETTLE_CYCLES = 8;      // margin past the queue and output register
  localparam int unsigned HOLD_CYCLES   = 250;    // long sink hold-off for the fill-up test
  localparam int unsigned TIMEOUT_NS    = 400000; // many times the slowest correct run

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [24:0] cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // data_byte[7:0]
  logic        s_axis_tlast = 1'b0; // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // out_byte, status_code, frame_length, bytes_consumed, pad
  logic        m_axis_tuser;        // item_kind

  // parse model state, one frame at a time
  logic [24:0]      capacity = nfp_pkg::MAX_PAYLOAD;
  nfp_pkg::phase_t  fr_phase = nfp_pkg::PH_DIGITS;
  logic [24:0]      fr_len   = '0;
  logic             fr_over  = 1'b0;
  logic [31:0]      fr_digits = '0;
  logic [24:0]      fr_left  = '0;
  logic             fr_upper = 1'b0;
  logic             fr_drop  = 1'b0;
  logic             fr_first = 1'b1;

  nfp_pkg::res_t frame_out_q[$];  // results the parser still owes us, oldest first
  logic [7:0]    buf_q[$];        // bytes of the buffer being assembled
  int unsigned   fail_count  = 0;
  int unsigned   bytes_sent  = 0;
  int unsigned   burst_left  = 0;
  int unsigned   gap_max     = 3;

  // sink side
  logic        sink_hold  = 1'b0;
  logic [1:0]  sink_mode  = 2'd0;
  logic [15:0] sink_cycle = '0;
  event        sink_hold_go;

  netstring_frame_parser_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // parse model
  // ---------------------------------------------------------------------------

  // every buffer end brings the frame back to its start; capacity is kept
  function automatic void reset_frame();
    fr_phase  = nfp_pkg::PH_DIGITS;
    fr_len    = '0;
    fr_over   = 1'b0;
    fr_digits = '0;
    fr_left   = '0;
    fr_upper  = 1'b0;
    fr_drop   = 1'b0;
    fr_first  = 1'b1;
  endfunction

  // status result ends the frame; later bytes are dropped until the buffer ends
  function automatic void close_frame(input nfp_pkg::status_t code, input logic lst);
    nfp_pkg::res_t r;
    logic [33:0]   total;
    r = '0;
    r.kind = nfp_pkg::KIND_STATUS;
    r.code = code;
    if (code == nfp_pkg::ST_OK) begin
      total = 34'(fr_digits) + 34'(fr_len) + 34'd2;
      r.flen = fr_len;
      r.consumed = (total > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
    end
    frame_out_q.push_back(r);
    if (lst) begin
      reset_frame();
    end else begin
      fr_phase = nfp_pkg::PH_DISCARD;
    end
  endfunction

  // one accepted byte in, zero or one result queued
  function automatic void parse_byte(input logic [7:0] b, input logic lst);
    logic [35:0]   grown;
    logic [7:0]    ob;
    nfp_pkg::res_t r;
    case (fr_phase)
      nfp_pkg::PH_DIGITS: begin
        if (b >= nfp_pkg::CH_ZERO && b <= nfp_pkg::CH_NINE) begin
          if (fr_digits != 32'hFFFF_FFFF) fr_digits++;
          // accumulator sticks once past the limit
          if (!fr_over) begin
            grown = 36'(fr_len) * 36'd10 + 36'(b - nfp_pkg::CH_ZERO);
            if (grown > 36'(nfp_pkg::MAX_PAYLOAD)) begin
              fr_over = 1'b1;
            end else begin
              fr_len = grown[24:0];
            end
          end
          if (lst) close_frame(fr_over ? nfp_pkg::ST_LENGTH : nfp_pkg::ST_FORMAT, 1'b1);
        end else if (fr_digits == 0) begin
          close_frame(nfp_pkg::ST_FORMAT, lst);
        end else if (fr_over) begin
          close_frame(nfp_pkg::ST_LENGTH, lst);
        end else if (b != nfp_pkg::CH_COLON) begin
          close_frame(nfp_pkg::ST_FORMAT, lst);
        end else if (lst) begin
          close_frame(nfp_pkg::ST_TRUNC, 1'b1);
        end else begin
          // capacity is taken here, at the colon
          fr_drop  = fr_len > capacity;
          fr_left  = fr_len;
          fr_phase = (fr_len == 0) ? nfp_pkg::PH_COMMA : nfp_pkg::PH_PAYLOAD;
        end
      end
      nfp_pkg::PH_PAYLOAD: begin
        if (lst) begin
          close_frame(nfp_pkg::ST_TRUNC, 1'b1);
        end else begin
          if (fr_first) begin
            fr_upper = (b == nfp_pkg::CH_BANG);
            fr_first = 1'b0;
          end
          if (fr_left != 0) fr_left--;
          if (fr_left == 0) fr_phase = nfp_pkg::PH_COMMA;
          if (!fr_drop) begin
            ob = b;
            if (fr_upper && b >= nfp_pkg::CH_LOW_A && b <= nfp_pkg::CH_LOW_Z) begin
              ob = b - nfp_pkg::CASE_BIT;
            end
            r = '0;
            r.kind = nfp_pkg::KIND_PAYLOAD;
            r.data = ob;
            frame_out_q.push_back(r);
          end
        end
      end
      nfp_pkg::PH_COMMA: begin
        if (b != nfp_pkg::CH_COMMA) begin
          close_frame(nfp_pkg::ST_FORMAT, lst);
        end else if (fr_drop) begin
          close_frame(nfp_pkg::ST_LENGTH, lst);
        end else begin
          close_frame(nfp_pkg::ST_OK, lst);
        end
      end
      default: begin
        if (lst) reset_frame();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result side: checks each accepted result and drives its own stall pattern
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result();
    nfp_pkg::res_t want;
    if (frame_out_q.size() == 0) begin
      $error("result with nothing expected: kind %0d data %h", m_axis_tuser, m_axis_tdata);
      fail_count++;
      return;
    end
    want = frame_out_q.pop_front();
    check_field("item_kind", want.kind, m_axis_tuser);
    check_field("out_byte", want.data, m_axis_tdata[7:0]);
    check_field("status_code", want.code, m_axis_tdata[9:8]);
    check_field("frame_length", want.flen, m_axis_tdata[34:10]);
    check_field("bytes_consumed", want.consumed, m_axis_tdata[66:35]);
    check_field("pad", 32'd0, m_axis_tdata[71:67]);
  endfunction

  // stall pattern drawn anew whenever the low seven bits of sink_cycle are zero: always
  // ready, coin flip, mostly stalled, or a fixed one-in-four stall; a hold-off overrides all of them
  always @(posedge clk) begin
    logic take;
    if (!rst && m_axis_tvalid && m_axis_tready) check_result();
    sink_cycle <= sink_cycle + 16'd1;
    if (sink_cycle[6:0] == 7'd0) sink_mode <= 2'($urandom_range(0, 3));
    case (sink_mode)
      2'd0: take = 1'b1;
      2'd1: take = 1'($urandom_range(0, 1));
      2'd2: take = ($urandom_range(0, 3) == 0);
      default: take = (sink_cycle[1:0] != 2'd0);
    endcase
    m_axis_tready <= take && !sink_hold;
  end

  // long hold-off on request, counted here so the sender keeps pushing meanwhile
  initial begin
    forever begin
      @(sink_hold_go);
      sink_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      sink_hold <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // one byte request; bursts of random length with random gaps in front
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= lst;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    parse_byte(b, lst);
    bytes_sent++;
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) buf_q.push_back(s[i]);
  endfunction

  // sends the assembled bytes; the last one ends the buffer if asked
  task automatic send_buf(input bit end_buf);
    int unsigned k;
    for (k = 0; k < buf_q.size(); k++) begin
      send_byte(buf_q[k], end_buf && (k == buf_q.size() - 1));
    end
    buf_q.delete();
  endtask

  // input idle, every result in, then a further wait for bytes that give no result
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (frame_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [24:0] cap);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    capacity = cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // lower-case heavy, with the bytes just outside a..z and anything else
  function automatic logic [7:0] rand_payload_byte();
    case ($urandom_range(0, 5))
      0, 1, 2: return 8'(nfp_pkg::CH_LOW_A + $urandom_range(0, 25));
      3:       return ($urandom_range(0, 1) == 0) ? nfp_pkg::CH_LOW_A - 8'd1
                                                  : nfp_pkg::CH_LOW_Z + 8'd1;
      default: return 8'($urandom);
    endcase
  endfunction

  // one buffer: mostly well-formed frames, some huge lengths, broken frames and noise
  task automatic build_random_frame();
    int unsigned pick, len, n;
    logic [7:0]  junk;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      n = $urandom_range(1, 6);
      repeat (n) buf_q.push_back(8'($urandom));
      return;
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 2)) buf_q.push_back(nfp_pkg::CH_ZERO);
    end
    if (pick < 85) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
      push_text($sformatf("%0d", len));
    end else if (pick < 93) begin
      case ($urandom_range(0, 2))
        0:       len = 32'(nfp_pkg::MAX_PAYLOAD);
        1:       len = 32'(nfp_pkg::MAX_PAYLOAD) + 1;
        default: len = $urandom_range(49, 32'(nfp_pkg::MAX_PAYLOAD));
      endcase
      push_text($sformatf("%0d", len));
    end else begin
      // far past the limit, long enough to keep the accumulator pinned
      len = 32'hFFFF_FFFF;
      buf_q.push_back(8'(nfp_pkg::CH_ZERO + $urandom_range(1, 9)));
      repeat ($urandom_range(8, 12)) begin
        buf_q.push_back(8'(nfp_pkg::CH_ZERO + $urandom_range(0, 9)));
      end
    end
    buf_q.push_back(nfp_pkg::CH_COLON);
    if (len <= 48) begin
      for (n = 0; n < len; n++) begin
        if (n == 0 && $urandom_range(0, 2) == 0) begin
          buf_q.push_back(nfp_pkg::CH_BANG);
        end else begin
          buf_q.push_back(rand_payload_byte());
        end
      end
      buf_q.push_back(nfp_pkg::CH_COMMA);
      if ($urandom_range(0, 6) == 0) repeat ($urandom_range(1, 3)) buf_q.push_back(8'($urandom));
    end else begin
      // too long to send whole: the buffer ends at the colon or inside the payload
      repeat ($urandom_range(0, 6)) buf_q.push_back(rand_payload_byte());
    end
    // break about a quarter of them: cut short or one byte overwritten
    if ($urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 1) == 0) begin
        n = $urandom_range(1, buf_q.size());
        while (buf_q.size() > n) junk = buf_q.pop_back();
      end else begin
        buf_q[$urandom_range(0, buf_q.size() - 1)] = 8'($urandom);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // good frame in upper-case mode, payload extremes 00 and ff passed unchanged
  task automatic test_ok_frames();
    push_text("4:!a");
    buf_q.push_back(8'h00);
    buf_q.push_back(8'hff);
    buf_q.push_back(nfp_pkg::CH_COMMA);
    send_buf(1'b1);
    settle();
  endtask

  // no digits, missing colon, wrong terminator followed by trailing bytes
  task automatic test_format_errors();
    push_text("x");
    send_buf(1'b1);
    push_text("3;");
    send_buf(1'b1);
    push_text("0:.z");
    send_buf(1'b1);
    settle();
  endtask

  // buffer ends among digits: past the limit gives length, else format
  task automatic test_length_errors();
    push_text("99999999");
    send_buf(1'b1);
    push_text("7");
    send_buf(1'b1);
    settle();
  endtask

  // colon as last byte, payload byte as last byte
  task automatic test_truncation();
    push_text("1:");
    send_buf(1'b1);
    push_text("2:a");
    send_buf(1'b1);
    settle();
  endtask

  // over-capacity payload is dropped; capacity change between digit and colon
  task automatic test_capacity();
    write_capacity(25'd0);
    push_text("1:a,");
    send_buf(1'b1);
    push_text("1");
    send_buf(1'b0);
    settle();
    write_capacity(25'd1);
    push_text(":b,");
    send_buf(1'b1);
    settle();
    write_capacity(nfp_pkg::MAX_PAYLOAD);
  endtask

  // sink holds off while a long frame keeps coming, so the input must stall
  task automatic test_backpressure();
    gap_max = 0;
    -> sink_hold_go;
    push_text("40:");
    repeat (40) buf_q.push_back(rand_payload_byte());
    buf_q.push_back(nfp_pkg::CH_COMMA);
    send_buf(1'b1);
    settle();
    gap_max = 3;
  endtask

  // random buffers in rounds, each with its own capacity and sender pace
  task automatic test_random_buffers();
    int unsigned round_no, stop_at;
    for (round_no = 0; round_no < 6; round_no++) begin
      case (round_no)
        0:       write_capacity(nfp_pkg::MAX_PAYLOAD);
        1:       write_capacity(25'd0);
        2:       write_capacity(25'($urandom_range(1, 12)));
        3:       write_capacity(25'h0FF_FFFF);
        4:       write_capacity(25'($urandom_range(0, 32'(nfp_pkg::MAX_PAYLOAD))));
        default: write_capacity(25'($urandom_range(5, 30)));
      endcase
      // every third round runs with no sender gaps at all
      gap_max = (round_no % 3 == 1) ? 0 : $urandom_range(2, 8);
      stop_at = bytes_sent + 220;
      while (bytes_sent < stop_at) begin
        build_random_frame();
        send_buf(1'b1);
      end
      settle();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_ok_frames();
    test_format_errors();
    test_length_errors();
    test_truncation();
    test_capacity();
    test_backpressure();
    test_random_buffers();

    // bounded final drain, then a further settle wait for stray results
    for (int i = 0; i < 4000 && frame_out_q.size() != 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (frame_out_q.size() != 0) begin
      $error("%0d expected results never arrived", frame_out_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
